// File: hdl/lfab_pkg.sv
// ----------------------------------------------------------------------------
// lfab_pkg
// Shared constants, types and helpers of the line folding block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfab_pkg;

    localparam int LINE_WIDTH = 8;
    localparam int FILL_W     = $clog2(LINE_WIDTH + 1);
    localparam int POS_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

    typedef logic [7:0]        char_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam char_t CH_NL  = 8'd10;
    localparam char_t CH_SP  = 8'd32;
    localparam char_t CH_TAB = 8'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_DROP,
        S_NL
    } state_t;

    function automatic logic is_blank(input char_t c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// File: hdl/lfab_in_if.sv
// ----------------------------------------------------------------------------
// lfab_in_if
// Request channel that carries one input text byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfab_in_if;
    logic              valid;
    logic              ready;
    lfab_pkg::char_t   in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

`default_nettype wire

// File: hdl/lfab_out_if.sv
// ----------------------------------------------------------------------------
// lfab_out_if
// Request channel that carries one emitted byte and its line end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfab_out_if;
    logic              valid;
    logic              ready;
    lfab_pkg::char_t   out_char;
    logic              line_end;

    modport source (output valid, output out_char, output line_end, input ready);
    modport sink   (input valid, input out_char, input line_end, output ready);
endinterface

`default_nettype wire

// File: hdl/lfab_cell.sv
// ----------------------------------------------------------------------------
// lfab_cell
// One character cell of the line buffer; loads a byte or takes its right
// neighbor's byte when the row shifts toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfab_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire logic            load,
    input  wire lfab_pkg::char_t load_data,
    input  wire lfab_pkg::char_t right_char,
    output lfab_pkg::char_t      char_q
);
    import lfab_pkg::*;

    char_t char_reg;
    char_t char_next;

    always_comb
    begin
        char_next = char_reg;
        if (load)
        begin
            char_next = load_data;
        end
        else if (shift)
        begin
            char_next = right_char;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_q = char_reg;

endmodule

`default_nettype wire

// File: hdl/line_fold_at_blank_core.sv
// ----------------------------------------------------------------------------
// line_fold_at_blank_core
// Folds a byte stream into lines of at most LINE_WIDTH characters, breaking
// at the last blank when the line holds one.
//
//   channel   role     payload              request taken when
//   in_req    sink     in_char              valid and ready high
//   out_req   source   out_char, line_end   valid and ready high
//
// A byte that is only stored goes straight into the row, so such bytes
// stream at one per cycle while no line is being emitted. A newline or
// fold takes the request, emits each byte of the line as the output takes
// it, drops a blank when it folds at one, and then emits the newline; the
// shifting row of character cells feeds the output from its first cell.
// Reset clears the fill count and blank tracking; buffer cells need none.
// A stalled output holds the row and no input is taken until the line ends.
// ----------------------------------------------------------------------------
`default_nettype none

module line_fold_at_blank_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfab_in_if.sink    in_req,
    lfab_out_if.source out_req
);
    import lfab_pkg::*;

    state_t state_reg, state_next;
    fill_t  fill_reg, fill_next;
    fill_t  count_reg, count_next;
    pos_t   blank_pos_reg, blank_pos_next;
    logic   blank_seen_reg, blank_seen_next;
    logic   fold_reg, fold_next;
    logic   drop_reg, drop_next;
    char_t  pend_reg, pend_next;

    logic   shift;
    logic   load_en;
    char_t  load_data;
    char_t  cell_char [LINE_WIDTH];

    genvar gi;
    generate
        for (gi = 0; gi < LINE_WIDTH; gi++)
        begin : g_cell
            char_t right_char;
            if (gi == LINE_WIDTH - 1)
            begin : g_last
                assign right_char = cell_char[gi];
            end
            else
            begin : g_mid
                assign right_char = cell_char[gi + 1];
            end

            lfab_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load       (load_en && (fill_reg == fill_t'(gi))),
                .load_data  (load_data),
                .right_char (right_char),
                .char_q     (cell_char[gi])
            );
        end
    endgenerate

    assign in_req.ready     = (state_reg == S_IDLE);
    assign out_req.valid    = (state_reg == S_EMIT) || (state_reg == S_NL);
    assign out_req.out_char = (state_reg == S_NL) ? CH_NL : cell_char[0];
    assign out_req.line_end = (state_reg == S_NL);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        blank_pos_next  = blank_pos_reg;
        blank_seen_next = blank_seen_reg;
        fold_next       = fold_reg;
        drop_next       = drop_reg;
        pend_next       = pend_reg;
        shift           = 1'b0;
        load_en         = 1'b0;
        load_data       = in_req.in_char;

        case (state_reg)
            S_IDLE:
            begin
                if (in_req.valid)
                begin
                    if (in_req.in_char == CH_NL)
                    begin
                        count_next = fill_reg;
                        fold_next  = 1'b0;
                        drop_next  = 1'b0;
                        state_next = (fill_reg == '0) ? S_NL : S_EMIT;
                    end
                    else if (fill_reg == fill_t'(LINE_WIDTH))
                    begin
                        pend_next = in_req.in_char;
                        fold_next = 1'b1;
                        if (!blank_seen_reg)
                        begin
                            count_next = fill_t'(LINE_WIDTH);
                            drop_next  = 1'b0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            count_next = fill_t'(blank_pos_reg);
                            drop_next  = 1'b1;
                            state_next = (blank_pos_reg == '0) ? S_DROP : S_EMIT;
                        end
                    end
                    else
                    begin
                        load_en   = 1'b1;
                        fill_next = fill_reg + fill_t'(1);
                        if (is_blank(in_req.in_char))
                        begin
                            blank_seen_next = 1'b1;
                            blank_pos_next  = fill_reg[POS_W-1:0];
                        end
                    end
                end
            end

            S_EMIT:
            begin
                if (out_req.ready)
                begin
                    shift      = 1'b1;
                    fill_next  = fill_reg - fill_t'(1);
                    count_next = count_reg - fill_t'(1);
                    if (count_reg == fill_t'(1))
                    begin
                        state_next = drop_reg ? S_DROP : S_NL;
                    end
                end
            end

            S_DROP:
            begin
                shift      = 1'b1;
                fill_next  = fill_reg - fill_t'(1);
                state_next = S_NL;
            end

            S_NL:
            begin
                if (out_req.ready)
                begin
                    state_next = S_IDLE;
                    if (fold_reg)
                    begin
                        load_en         = 1'b1;
                        load_data       = pend_reg;
                        fill_next       = fill_reg + fill_t'(1);
                        blank_seen_next = is_blank(pend_reg);
                        blank_pos_next  = is_blank(pend_reg) ? fill_reg[POS_W-1:0] : '0;
                    end
                    else
                    begin
                        fill_next       = '0;
                        blank_seen_next = 1'b0;
                        blank_pos_next  = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            count_reg      <= '0;
            blank_pos_reg  <= '0;
            blank_seen_reg <= 1'b0;
            fold_reg       <= 1'b0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            blank_pos_reg  <= blank_pos_next;
            blank_seen_reg <= blank_seen_next;
            fold_reg       <= fold_next;
            drop_reg       <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// File: hdl/lfab_checker.sv
// ----------------------------------------------------------------------------
// lfab_checker
// Port level checks of the line folding block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfab_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire lfab_pkg::char_t in_char,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire lfab_pkg::char_t out_char,
    input wire logic            line_end
);
    import lfab_pkg::*;

    // No input is taken while a line is being emitted.
    a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while output is valid");

    // A newline always produces output before the next input.
    a_nl_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_char == CH_NL)) |=> !in_ready)
        else $error("newline request did not start a line");

    // The end of a line hands control back to the input side.
    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && line_end) |=> (in_ready && !out_valid))
        else $error("block not idle after line end");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_char) && $stable(line_end)))
        else $error("stalled output changed");

endmodule

bind line_fold_at_blank_core lfab_checker u_lfab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_char   (in_req.in_char),
    .out_valid (out_req.valid),
    .out_ready (out_req.ready),
    .out_char  (out_req.out_char),
    .line_end  (out_req.line_end)
);

`default_nettype wire

// File: dv/line_fold_at_blank_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fold_at_blank_core_check
// Watches both request channels of the line folding block. It keeps its own
// line buffer, fill count and last blank position, works out the bytes that
// each accepted input byte must produce, and compares every accepted output
// request with the oldest expected byte.
// ----------------------------------------------------------------------------
module line_fold_at_blank_core_check (
    input  wire logic clk,
    input  wire logic rst_n,
    lfab_in_if        in_req,
    lfab_out_if       out_req,
    input  wire logic end_check,
    output int        errors,
    output int        waiting,
    output int        bytes_in,
    output int        bytes_out,
    output int        lines_out,
    output int        blank_folds,
    output int        hard_folds
);
    import lfab_pkg::*;

    typedef struct packed {
        char_t ch;
        logic  eol;
    } line_byte_t;

    line_byte_t pending_bytes [$];
    char_t      line_buf [LINE_WIDTH];
    int         fill;
    int         last_gap;
    bit         gap_seen;
    bit         end_done;

    function automatic bit word_gap(input char_t c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    task automatic flag_mismatch(input string what);
        if (errors < 40)
            $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic queue_line(input int n);
        for (int i = 0; i < n; i++)
            pending_bytes.push_back('{ch: line_buf[i], eol: 1'b0});
        pending_bytes.push_back('{ch: CH_NL, eol: 1'b1});
        lines_out++;
    endtask

    task automatic fold_byte(input char_t c);
        int rest;
        if (c == CH_NL)
        begin
            queue_line(fill);
            fill = 0;
            last_gap = 0;
            gap_seen = 1'b0;
        end
        else if (fill >= LINE_WIDTH)
        begin
            if (!gap_seen)
            begin
                queue_line(LINE_WIDTH);
                line_buf[0] = c;
                fill = 1;
                gap_seen = word_gap(c);
                last_gap = 0;
                hard_folds++;
            end
            else
            begin
                rest = LINE_WIDTH - last_gap - 1;
                queue_line(last_gap);
                for (int i = 0; i < rest; i++)
                    line_buf[i] = line_buf[last_gap + 1 + i];
                line_buf[rest] = c;
                gap_seen = 1'b0;
                last_gap = 0;
                for (int i = rest; i >= 0; i--)
                begin
                    if (!gap_seen && word_gap(line_buf[i]))
                    begin
                        gap_seen = 1'b1;
                        last_gap = i;
                    end
                end
                fill = rest + 1;
                blank_folds++;
            end
        end
        else
        begin
            line_buf[fill] = c;
            if (word_gap(c))
            begin
                gap_seen = 1'b1;
                last_gap = fill;
            end
            fill++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_byte_t want;
        if (!rst_n)
        begin
            pending_bytes.delete();
            fill = 0;
            last_gap = 0;
            gap_seen = 1'b0;
            end_done = 1'b0;
            waiting <= 0;
        end
        else
        begin
            if (out_req.valid && out_req.ready)
            begin
                bytes_out++;
                if (pending_bytes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected output byte %02h, line_end %b",
                                            out_req.out_char, out_req.line_end));
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_req.out_char !== want.ch)
                        flag_mismatch($sformatf("out_char %02h, expected %02h",
                                                out_req.out_char, want.ch));
                    if (out_req.line_end !== want.eol)
                        flag_mismatch($sformatf("line_end %b, expected %b on byte %02h",
                                                out_req.line_end, want.eol, want.ch));
                end
            end
            if (in_req.valid && in_req.ready)
            begin
                bytes_in++;
                fold_byte(in_req.in_char);
            end
            if (end_check && !end_done)
            begin
                end_done = 1'b1;
                if (pending_bytes.size() != 0)
                    flag_mismatch($sformatf("%0d expected bytes never came out",
                                            pending_bytes.size()));
            end
            waiting <= pending_bytes.size();
        end
    end

endmodule

// File: dv/line_fold_at_blank_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fold_at_blank_core_tb
// Feeds the line folding block with a few hand-picked lines that hit its
// corner cases, then with random words, blanks, newlines and stray bytes,
// while both channels stall at random. A separate checker predicts and
// compares every output byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module line_fold_at_blank_core_tb;

    import lfab_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic take = 1'b0;
    logic steady = 1'b0;
    logic end_check = 1'b0;
    int   sent = 0;
    int   errors;
    int   waiting;
    int   bytes_in;
    int   bytes_out;
    int   lines_out;
    int   blank_folds;
    int   hard_folds;

    char_t opening_text [$] = {
        CH_NL,
        8'h00, 8'hFF, 8'h80, 8'h7F, "a", "b", "c", "d", CH_SP,
        "x", "y", "z", "u", "v", "w", CH_TAB, "Q",
        "R", "S", "T", "U", "V", "W", "X", CH_NL
    };

    lfab_in_if  in_req ();
    lfab_out_if out_req ();

    assign out_req.ready = take;

    always #10 clk = ~clk;

    always @(posedge clk)
        take <= steady || ($urandom_range(0, 99) >= 29);

    line_fold_at_blank_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req.sink),
        .out_req (out_req.source)
    );

    line_fold_at_blank_core_check fold_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_req      (in_req),
        .out_req     (out_req),
        .end_check   (end_check),
        .errors      (errors),
        .waiting     (waiting),
        .bytes_in    (bytes_in),
        .bytes_out   (bytes_out),
        .lines_out   (lines_out),
        .blank_folds (blank_folds),
        .hard_folds  (hard_folds)
    );

    task automatic send_byte(input char_t c);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                in_req.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_req.valid <= 1'b1;
        in_req.in_char <= c;
        @(posedge clk);
        while (!in_req.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_for_output_drain();
        in_req.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int roll;
        int word_len;
        in_req.valid = 1'b0;
        in_req.in_char = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_text[i])
            send_byte(opening_text[i]);

        // Hold the sender until the block has emitted everything it owes.
        wait_for_output_drain();

        while (sent < 460)
        begin
            steady <= (sent >= 200 && sent < 290);
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                send_byte(char_t'($urandom_range(0, 255)));
            end
            else
            begin
                word_len = $urandom_range(1, 10);
                for (int j = 0; j < word_len; j++)
                    send_byte(char_t'($urandom_range(33, 126)));
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    send_byte(CH_SP);
                else if (roll < 75)
                    send_byte(CH_TAB);
                else if (roll < 88)
                    send_byte(CH_NL);
                else
                begin
                    send_byte(CH_SP);
                    send_byte(CH_TAB);
                end
            end
        end
        steady <= 1'b0;

        wait_for_output_drain();
        repeat (24) @(posedge clk);
        end_check <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Sent %0d bytes; checked %0d output bytes over %0d lines.",
                 bytes_in, bytes_out, lines_out);
        $display("Lines broken at a blank: %0d, lines cut with no blank: %0d.",
                 blank_folds, hard_folds);
        if (errors == 0)
            $display("line_fold_at_blank_core: match");
        else
            $display("line_fold_at_blank_core: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out waiting for the block.");
        $display("line_fold_at_blank_core: mismatch");
        $finish;
    end

endmodule
